@@ rtl/core/piecewise_linear_curve_lut_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise-linear curve evaluator
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CURVE_LUT_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_LUT_DEFINES_SVH

// Same-cycle implication.
`define PLC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define PLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// Piecewise-linear curve evaluator package
// Request and result types, function codes and controller interface types.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int PLC_MAX_POINTS = 16;
    localparam int LEVEL_W        = 8;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_EVAL   = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [LEVEL_W-1:0] point_in;
        logic [LEVEL_W-1:0] point_out;
        logic [LEVEL_W-1:0] query_index;
    } plc_req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               no_points;
    } plc_res_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic begin_eval;
        logic emit_empty;
        logic rd_en;
        logic emit_data;
        logic load_hi;
        logic step;
        logic mul_a;
        logic mul_b;
        logic div_step;
        logic emit_quot;
    } plc_ctrl_t;

    typedef struct packed {
        logic count_zero;
        logic found;
        logic exact_or_first;
        logic last;
        logic div_last;
    } plc_stat_t;

endpackage

@@ rtl/core/plc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module plc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/plc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Piecewise-linear curve evaluator controller
// Sequences the breakpoint search, the products and the serial division.
// ----------------------------------------------------------------------------
module plc_ctrl
    import plc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] func,
    input  plc_stat_t  stat,
    output plc_ctrl_t  ctrl,
    output logic       busy
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_MUL_A = 6'b001000,
        ST_MUL_B = 6'b010000,
        ST_DIV   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        FUNC_CLEAR:  ctrl.clear = 1'b1;
                        FUNC_APPEND: ctrl.append = 1'b1;
                        FUNC_EVAL:
                        begin
                            if (stat.count_zero)
                            begin
                                ctrl.emit_empty = 1'b1;
                            end
                            else
                            begin
                                ctrl.begin_eval = 1'b1;
                                state_next      = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                ctrl.rd_en = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.found)
                begin
                    if (stat.exact_or_first)
                    begin
                        ctrl.emit_data = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        ctrl.load_hi = 1'b1;
                        state_next   = ST_MUL_A;
                    end
                end
                else if (stat.last)
                begin
                    ctrl.emit_data = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    ctrl.step  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_MUL_A:
            begin
                ctrl.mul_a = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                ctrl.mul_b = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (stat.div_last)
                begin
                    ctrl.emit_quot = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ rtl/core/plc_datapath.sv @@
// ----------------------------------------------------------------------------
// Piecewise-linear curve evaluator datapath
// Breakpoint store, search registers, products, serial divider and result.
// ----------------------------------------------------------------------------
module plc_datapath
    import plc_pkg::*;
#(
    parameter int MAX_POINTS = PLC_MAX_POINTS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  plc_req_t  req,
    input  plc_ctrl_t ctrl,
    output plc_stat_t stat,
    output logic      done,
    output plc_res_t  result
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int BP_W  = 2 * LEVEL_W;

    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [2:0]         bit_cnt_reg;
    logic               done_reg;

    logic [LEVEL_W-1:0] idx_reg;
    logic [LEVEL_W-1:0] lo_in_reg;
    logic [LEVEL_W-1:0] lo_out_reg;
    logic [LEVEL_W-1:0] hi_in_reg;
    logic [LEVEL_W-1:0] hi_out_reg;
    logic [BP_W-1:0]    prod_reg;
    logic [LEVEL_W-1:0] rem_reg;
    logic [LEVEL_W-1:0] dvd_reg;
    logic [LEVEL_W-1:0] quot_reg;
    logic [LEVEL_W-1:0] run_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               no_points_reg;

    logic               full;
    logic [BP_W-1:0]    rd_data;
    logic [LEVEL_W-1:0] rd_in;
    logic [LEVEL_W-1:0] rd_out;
    logic [LEVEL_W-1:0] hi_minus_idx;
    logic [LEVEL_W-1:0] offset;
    logic [BP_W-1:0]    num;
    logic [LEVEL_W:0]   trial;
    logic [LEVEL_W:0]   trial_diff;
    logic               ge;
    logic [LEVEL_W-1:0] quot_next;

    assign full = (count_reg == CNT_W'(MAX_POINTS));

    plc_ram #(
        .WIDTH (BP_W),
        .DEPTH (MAX_POINTS)
    ) u_bp_ram (
        .clk   (clk),
        .we    (ctrl.append && !full),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({req.point_in, req.point_out}),
        .re    (ctrl.rd_en),
        .raddr (j_reg),
        .rdata (rd_data)
    );

    assign rd_in  = rd_data[BP_W-1:LEVEL_W];
    assign rd_out = rd_data[LEVEL_W-1:0];

    assign hi_minus_idx = hi_in_reg - idx_reg;
    assign offset       = idx_reg - lo_in_reg;
    assign num          = prod_reg + BP_W'(hi_out_reg) * BP_W'(offset);

    assign trial      = {rem_reg, dvd_reg[LEVEL_W-1]};
    assign ge         = (trial >= {1'b0, run_reg});
    assign trial_diff = trial - {1'b0, run_reg};
    assign quot_next  = {quot_reg[LEVEL_W-2:0], ge};

    assign stat.count_zero     = (count_reg == '0);
    assign stat.found          = (rd_in >= idx_reg);
    assign stat.exact_or_first = (rd_in == idx_reg) || (j_reg == '0);
    assign stat.last           = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign stat.div_last       = (bit_cnt_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            j_reg       <= '0;
            bit_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.emit_empty || ctrl.emit_data || ctrl.emit_quot;
            if (ctrl.clear)
            begin
                count_reg <= '0;
            end
            else if (ctrl.append && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (ctrl.begin_eval)
            begin
                j_reg <= '0;
            end
            else if (ctrl.step)
            begin
                j_reg <= j_reg + IDX_W'(1);
            end
            if (ctrl.mul_b)
            begin
                bit_cnt_reg <= '0;
            end
            else if (ctrl.div_step)
            begin
                bit_cnt_reg <= bit_cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.begin_eval)
        begin
            idx_reg <= req.query_index;
        end
        if (ctrl.step)
        begin
            lo_in_reg  <= rd_in;
            lo_out_reg <= rd_out;
        end
        if (ctrl.load_hi)
        begin
            hi_in_reg  <= rd_in;
            hi_out_reg <= rd_out;
        end
        if (ctrl.mul_a)
        begin
            prod_reg <= BP_W'(lo_out_reg) * BP_W'(hi_minus_idx);
        end
        if (ctrl.mul_b)
        begin
            rem_reg <= num[BP_W-1:LEVEL_W];
            dvd_reg <= num[LEVEL_W-1:0];
            run_reg <= hi_in_reg - lo_in_reg;
        end
        if (ctrl.div_step)
        begin
            rem_reg  <= ge ? trial_diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
            dvd_reg  <= {dvd_reg[LEVEL_W-2:0], 1'b0};
            quot_reg <= quot_next;
        end
        if (ctrl.emit_empty)
        begin
            level_reg     <= '0;
            no_points_reg <= 1'b1;
        end
        else if (ctrl.emit_data)
        begin
            level_reg     <= rd_out;
            no_points_reg <= 1'b0;
        end
        else if (ctrl.emit_quot)
        begin
            level_reg     <= quot_next;
            no_points_reg <= 1'b0;
        end
    end

    assign done             = done_reg;
    assign result.level     = level_reg;
    assign result.no_points = no_points_reg;

endmodule

@@ rtl/core/piecewise_linear_curve_lut.sv @@
// ----------------------------------------------------------------------------
// Piecewise-linear curve evaluator
// Breakpoint store with search and linear interpolation of an 8-bit level.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Clear and append
// never raise busy and give no result. An evaluate request gives exactly
// one result, shown on result for a single cycle with done high, and the
// receiver cannot hold it off. With an empty store the result follows in
// the next cycle. Otherwise the search examines the breakpoints in order,
// each through a registered store read (ST_READ, then ST_CHECK); an
// interpolated result then passes the multiply states ST_MUL_A and
// ST_MUL_B and the bit-serial divider in ST_DIV before it is shown.
// ----------------------------------------------------------------------------
`include "piecewise_linear_curve_lut_defines.svh"

module piecewise_linear_curve_lut
    import plc_pkg::*;
#(
    parameter int MAX_POINTS = PLC_MAX_POINTS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  plc_req_t cmd,
    output logic     busy,
    output logic     done,
    output plc_res_t result
);

    plc_ctrl_t ctrl;
    plc_stat_t stat;

    plc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (cmd.func),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    plc_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (cmd),
        .ctrl   (ctrl),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

    `PLC_ASSERT_IMPL(a_done_has_cause, done, $past(busy || start))
    `PLC_ASSERT_IMPL(a_done_when_idle, done, !busy)
    `PLC_ASSERT_IMPL(a_empty_level_zero, done && result.no_points, result.level == '0)
    `PLC_ASSERT_NEXT(a_eval_progress, start && !busy && (cmd.func == FUNC_EVAL), busy || done)

endmodule

@@ tb/piecewise_linear_curve_lut_tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the piecewise-linear curve evaluator
// Loads breakpoint curves, evaluates indices and checks every result against
// an independent integer model of the search and the interpolation. Directed
// corner cases come first, then a full tone table sweep and random curves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_curve_lut_tb;

    import plc_pkg::*;

    localparam int         MAX_POINTS    = PLC_MAX_POINTS;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int         ITEM_TARGET   = 450;
    localparam int         SETTLE_CYCLES = 2 * MAX_POINTS + 16;
    localparam int         CYCLE_LIMIT   = 200000;

    logic     clk;
    logic     rst_n;
    logic     start;
    plc_req_t cmd;
    logic     busy;
    logic     done;
    plc_res_t result;

    logic [LEVEL_W-1:0] knot_in  [MAX_POINTS];
    logic [LEVEL_W-1:0] knot_out [MAX_POINTS];
    int                 knot_count = 0;
    plc_res_t           pending_levels [$];

    logic [LEVEL_W-1:0] curve_in  [24];
    logic [LEVEL_W-1:0] curve_out [24];

    int error_count = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    bit gaps_on;

    piecewise_linear_curve_lut dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [LEVEL_W-1:0] interpolate_level(input logic [LEVEL_W-1:0] idx);
        int j;
        int run;
        int rise;
        int offset;
        int num;
        j = 0;
        while (j < knot_count && knot_in[j] < idx)
            j++;
        if (j >= knot_count)
            return knot_out[knot_count - 1];
        if (knot_in[j] == idx || j == 0)
            return knot_out[j];
        run    = int'(knot_in[j]) - int'(knot_in[j - 1]);
        rise   = int'(knot_out[j]) - int'(knot_out[j - 1]);
        offset = int'(idx) - int'(knot_in[j - 1]);
        num    = int'(knot_out[j - 1]) * run + rise * offset;
        return LEVEL_W'(num / run);
    endfunction

    function automatic void track_request(input plc_req_t req);
        plc_res_t want;
        case (req.func)
            FUNC_CLEAR:
                knot_count = 0;
            FUNC_APPEND:
                if (knot_count < MAX_POINTS)
                begin
                    knot_in[knot_count]  = req.point_in;
                    knot_out[knot_count] = req.point_out;
                    knot_count++;
                end
            FUNC_EVAL:
            begin
                if (knot_count == 0)
                begin
                    want.level     = '0;
                    want.no_points = 1'b1;
                end
                else
                begin
                    want.level     = interpolate_level(req.query_index);
                    want.no_points = 1'b0;
                end
                pending_levels = {pending_levels, want};
            end
            default:
                ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        plc_res_t want;
        if (rst_n && done)
        begin
            if (pending_levels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual level %0d no_points %0b",
                         $time, result.level, result.no_points);
                error_count++;
            end
            else
            begin
                want = pending_levels.pop_front();
                if (result.level !== want.level)
                begin
                    $display("%0t: level mismatch, expected %0d, actual %0d",
                             $time, want.level, result.level);
                    error_count++;
                end
                if (result.no_points !== want.no_points)
                begin
                    $display("%0t: no_points mismatch, expected %0b, actual %0b",
                             $time, want.no_points, result.no_points);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input plc_req_t req);
        while (gaps_on && $urandom_range(99) < 31)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        track_request(req);
        if (req.func != FUNC_UNUSED)
            items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_levels.size() != 0);
    endtask

    task automatic do_clear();
        plc_req_t req;
        req.func        = FUNC_CLEAR;
        req.point_in    = LEVEL_W'($urandom);
        req.point_out   = LEVEL_W'($urandom);
        req.query_index = LEVEL_W'($urandom);
        send_request(req);
    endtask

    task automatic do_append(input logic [LEVEL_W-1:0] pin, input logic [LEVEL_W-1:0] pout);
        plc_req_t req;
        req.func        = FUNC_APPEND;
        req.point_in    = pin;
        req.point_out   = pout;
        req.query_index = LEVEL_W'($urandom);
        send_request(req);
    endtask

    task automatic do_eval(input logic [LEVEL_W-1:0] idx);
        plc_req_t req;
        req.func        = FUNC_EVAL;
        req.point_in    = LEVEL_W'($urandom);
        req.point_out   = LEVEL_W'($urandom);
        req.query_index = idx;
        send_request(req);
    endtask

    task automatic do_noise();
        plc_req_t req;
        req.func        = 2'($urandom_range(3));
        req.point_in    = LEVEL_W'($urandom);
        req.point_out   = LEVEL_W'($urandom);
        req.query_index = LEVEL_W'($urandom);
        send_request(req);
    endtask

    // Ordered curves keep strictly rising input levels with room left for
    // the remaining points; unordered ones are fully random.
    task automatic load_curve(input int count, input bit ordered);
        int i;
        int lo_bound;
        int hi_bound;
        int stretch;
        int v;
        lo_bound = 0;
        for (i = 0; i < count; i++)
        begin
            if (ordered)
            begin
                hi_bound = 255 - (count - 1 - i);
                stretch  = (hi_bound - lo_bound) * 2 / (count - i);
                v        = lo_bound + int'($urandom_range(stretch, 0));
                if (v > hi_bound)
                    v = hi_bound;
                lo_bound = v + 1;
            end
            else
                v = int'($urandom_range(255));
            curve_in[i]  = LEVEL_W'(v);
            curve_out[i] = LEVEL_W'($urandom);
            do_append(curve_in[i], curve_out[i]);
        end
    endtask

    function automatic logic [LEVEL_W-1:0] pick_index(input int count);
        int sel;
        int v;
        sel = int'($urandom_range(3));
        if (count == 0 || sel < 2)
            return LEVEL_W'($urandom_range(255));
        if (sel == 2)
        begin
            v = int'(curve_in[$urandom_range(count - 1)]) + int'($urandom_range(2)) - 1;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            return LEVEL_W'(v);
        end
        return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    endfunction

    task automatic test_empty_store();
        do_eval(8'd0);
        do_eval(8'd255);
        do_clear();
        do_eval(8'd128);
    endtask

    task automatic test_single_point();
        do_append(8'd128, 8'd77);
        do_eval(8'd0);
        do_eval(8'd128);
        do_eval(8'd255);
    endtask

    task automatic test_interpolation();
        do_clear();
        do_append(8'd10, 8'd0);
        do_append(8'd128, 8'd255);
        do_append(8'd250, 8'd3);
        do_eval(8'd5);
        do_eval(8'd10);
        do_eval(8'd11);
        do_eval(8'd128);
        do_eval(8'd200);
        do_eval(8'd255);
    endtask

    task automatic test_unordered_points();
        do_clear();
        do_append(8'd50, 8'd0);
        do_append(8'd30, 8'd100);
        do_append(8'd30, 8'd7);
        do_append(8'd200, 8'd255);
        do_eval(8'd100);
        do_eval(8'd40);
    endtask

    task automatic test_unused_code();
        plc_req_t req;
        req.func        = FUNC_UNUSED;
        req.point_in    = 8'hFF;
        req.point_out   = 8'hFF;
        req.query_index = 8'hFF;
        send_request(req);
        do_eval(8'd220);
        drain_results();
    endtask

    task automatic test_full_store();
        int n;
        do_clear();
        load_curve(MAX_POINTS + 4, 1'b1);
        do_eval(curve_in[MAX_POINTS + 2]);
        do_eval(8'd255);
        for (n = 0; n < 4; n++)
            do_eval(pick_index(MAX_POINTS + 4));
    endtask

    task automatic test_tone_sweep();
        int idx;
        drain_results();
        gaps_on = 1'b0;
        do_clear();
        load_curve(int'($urandom_range(MAX_POINTS, 2)), 1'b1);
        for (idx = 0; idx < 256; idx++)
            do_eval(LEVEL_W'(idx));
        gaps_on = 1'b1;
        drain_results();
    endtask

    task automatic test_random_curves();
        int sel;
        int count;
        int n;
        int evals;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(99) < 10)
                do_noise();
            else
            begin
                if ($urandom_range(19) != 0)
                    do_clear();
                sel = int'($urandom_range(19));
                if (sel == 0)
                    count = 0;
                else if (sel == 1)
                    count = int'($urandom_range(MAX_POINTS + 4, MAX_POINTS + 1));
                else
                    count = int'($urandom_range(MAX_POINTS, 1));
                load_curve(count, $urandom_range(6) != 0);
                evals = int'($urandom_range(6, 1));
                for (n = 0; n < evals; n++)
                    do_eval(pick_index(count));
            end
            if ($urandom_range(9) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        gaps_on = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_single_point();
        test_interpolation();
        test_unordered_points();
        test_unused_code();
        test_full_store();
        test_tone_sweep();
        test_random_curves();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_levels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
